FILE: rtl/lrhs_pkg.sv
// Package for the LED ring hue scanner: ring size, controller states,
// command and status structs between controller and datapath, color wheel.
// No dependencies.
package lrhs_pkg;

    localparam int LED_COUNT = 12;
    localparam int IDX_W     = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;

    localparam logic [7:0]  STEP_RESET     = 8'd42;
    localparam logic [7:0]  HUE_THIRD      = 8'd85;
    localparam logic [7:0]  HUE_TWO_THIRDS = 8'd170;
    localparam logic [7:0]  FULL_SCALE     = 8'd255;
    localparam logic [23:0] GAMMA_ROUND    = 24'd32768;

    // Channel codes used while the gamma values are built.
    localparam logic [1:0] CH_G = 2'd0;
    localparam logic [1:0] CH_R = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CUBE,
        ST_FILL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic             fill_init;
        logic             gamma_square;
        logic             gamma_cube;
        logic [1:0]       ch;
        logic             fill_write;
        logic             frame_commit;
        logic             emit_load;
        logic [IDX_W-1:0] emit_idx;
        logic             emit_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic color_t wheel_of(input logic [7:0] h);
        color_t     c;
        logic [7:0] k;
        logic [7:0] k3;
        if (h < HUE_THIRD) begin
            k = h;
        end
        else if (h < HUE_TWO_THIRDS) begin
            k = h - HUE_THIRD;
        end
        else begin
            k = h - HUE_TWO_THIRDS;
        end
        k3 = 8'({k, 1'b0} + {1'b0, k});
        if (h < HUE_THIRD) begin
            c.r = k3;
            c.g = FULL_SCALE - k3;
            c.b = 8'd0;
        end
        else if (h < HUE_TWO_THIRDS) begin
            c.r = FULL_SCALE - k3;
            c.g = 8'd0;
            c.b = k3;
        end
        else begin
            c.r = 8'd0;
            c.g = k3;
            c.b = FULL_SCALE - k3;
        end
        return c;
    endfunction

endpackage

FILE: rtl/led_ring_hue_scanner.sv
// Top level of the LED ring hue scanner frame generator.
// Depends on lrhs_pkg, lrhs_ctrl and lrhs_datapath.
//
//  port group      direction  handshake              contents
//  in              sink       in_valid / in_ready    advance
//  out             source     out_valid / out_ready  led_position, green, red, blue, frame_end
//  cfg             sink       cfg_write_en           cfg_write_data (brightness step)
//
// A tick with advance set first builds the gamma cube of each channel in two passes (square,
// then cube), then writes the tail slots, one slot write per cycle, before the first word;
// a resend goes straight to output. Words then leave at up to one a cycle.
// A new tick is taken once the last word of the frame is in the output register.
// Reset clears the pixel store, start position and hue, and loads the step with 42.
// A stall on out_ready holds the current word and the sequencer.
module led_ring_hue_scanner (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       advance,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] led_position,
    output logic [7:0] green,
    output logic [7:0] red,
    output logic [7:0] blue,
    output logic       frame_end,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data
);

    lrhs_pkg::cmd_t    cmd;
    lrhs_pkg::status_t status;

    lrhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .advance  (advance),
        .status   (status),
        .cmd      (cmd)
    );

    lrhs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .led_position   (led_position),
        .green          (green),
        .red            (red),
        .blue           (blue),
        .frame_end      (frame_end)
    );

    // A word is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> status.out_free)
        else $error("word loaded over an untaken word");

    // One tick at a time: no new tick is taken right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a tick is in progress");

    // Each cube pass follows its square pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gamma_cube |-> $past(cmd.gamma_square))
        else $error("gamma cube without square");

    // Filling the store and emitting never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_write |-> !cmd.emit_load)
        else $error("store written during output");

endmodule

FILE: rtl/lrhs_ctrl.sv
// Controller for the LED ring hue scanner: sequences gamma, tail fill and
// pixel output. Depends on lrhs_pkg.
module lrhs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               advance,
    input  lrhs_pkg::status_t  status,
    output lrhs_pkg::cmd_t     cmd
);

    lrhs_pkg::state_t           state_reg, state_next;
    logic [1:0]                 ch_reg, ch_next;
    logic [lrhs_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= lrhs_pkg::ST_IDLE;
            ch_reg    <= lrhs_pkg::CH_G;
            cnt_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.ch       = ch_reg;
        cmd.emit_idx = cnt_reg;
        cmd.emit_last = (cnt_reg == lrhs_pkg::IDX_W'(lrhs_pkg::LED_COUNT - 1));
        case (state_reg)
            lrhs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cnt_next = '0;
                    ch_next  = lrhs_pkg::CH_G;
                    if (advance) begin
                        cmd.fill_init = 1'b1;
                        state_next    = lrhs_pkg::ST_SQUARE;
                    end
                    else begin
                        state_next = lrhs_pkg::ST_EMIT;
                    end
                end
            end
            lrhs_pkg::ST_SQUARE: begin
                cmd.gamma_square = 1'b1;
                state_next       = lrhs_pkg::ST_CUBE;
            end
            lrhs_pkg::ST_CUBE: begin
                cmd.gamma_cube = 1'b1;
                if (ch_reg == lrhs_pkg::CH_B) begin
                    state_next = lrhs_pkg::ST_FILL;
                end
                else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = lrhs_pkg::ST_SQUARE;
                end
            end
            lrhs_pkg::ST_FILL: begin
                cmd.fill_write = 1'b1;
                if (cnt_reg == lrhs_pkg::IDX_W'(lrhs_pkg::LED_COUNT - 2)) begin
                    cmd.frame_commit = 1'b1;
                    cnt_next         = '0;
                    state_next       = lrhs_pkg::ST_EMIT;
                end
                else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lrhs_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (cmd.emit_last) begin
                        state_next = lrhs_pkg::ST_IDLE;
                    end
                    else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lrhs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lrhs_datapath.sv
// Datapath for the LED ring hue scanner: position and hue registers, gamma
// multipliers, tail brightness scaling, pixel store and output word register.
// Depends on lrhs_pkg.
module lrhs_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [7:0]        cfg_write_data,
    input  lrhs_pkg::cmd_t    cmd,
    output lrhs_pkg::status_t status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        led_position,
    output logic [7:0]        green,
    output logic [7:0]        red,
    output logic [7:0]        blue,
    output logic              frame_end
);

    logic [7:0]                 step_reg;
    logic [lrhs_pkg::IDX_W-1:0] start_reg;
    logic [7:0]                 hue_reg;
    logic [lrhs_pkg::IDX_W-1:0] slot_reg;
    logic [7:0]                 bright_reg;
    logic                       over_reg;
    logic [15:0]                sq_reg;
    logic [7:0]                 gam_g_reg, gam_r_reg, gam_b_reg;
    logic [23:0]                pix_reg [lrhs_pkg::LED_COUNT];
    logic                       out_valid_reg;
    logic [3:0]                 pos_reg;
    lrhs_pkg::color_t           out_px_reg;
    logic                       last_reg;

    lrhs_pkg::color_t           wheel;
    logic [7:0]                 chan_x;
    logic [15:0]                sq_prod;
    logic [23:0]                cube_sum;
    logic [7:0]                 bright_eff;
    logic [8:0]                 bright_sum;
    logic [15:0]                scaled_g, scaled_r, scaled_b;
    logic [lrhs_pkg::IDX_W-1:0] last_idx;

    assign last_idx = lrhs_pkg::IDX_W'(lrhs_pkg::LED_COUNT - 1);
    assign wheel    = lrhs_pkg::wheel_of(hue_reg);

    always_comb begin
        case (cmd.ch)
            lrhs_pkg::CH_G: chan_x = wheel.g;
            lrhs_pkg::CH_R: chan_x = wheel.r;
            lrhs_pkg::CH_B: chan_x = wheel.b;
            default:        chan_x = 8'd0;
        endcase
    end

    // Cube is built in two passes, each with its own multiplier: x*x, then (x*x)*x.
    assign sq_prod  = chan_x * chan_x;
    assign cube_sum = 24'(sq_reg * chan_x) + lrhs_pkg::GAMMA_ROUND;

    // Brightness grows by the step per slot; once past 255 it stays past.
    assign bright_eff = over_reg ? 8'd0 : bright_reg;
    assign bright_sum = {1'b0, bright_reg} + {1'b0, step_reg};
    assign scaled_g   = gam_g_reg * bright_eff;
    assign scaled_r   = gam_r_reg * bright_eff;
    assign scaled_b   = gam_b_reg * bright_eff;

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg      <= lrhs_pkg::STEP_RESET;
            start_reg     <= '0;
            hue_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lrhs_pkg::LED_COUNT; i++) begin
                pix_reg[i] <= 24'd0;
            end
        end
        else begin
            if (cfg_write_en) begin
                step_reg <= cfg_write_data;
            end
            if (cmd.frame_commit) begin
                start_reg <= (start_reg == last_idx) ? '0 : start_reg + 1'b1;
                hue_reg   <= hue_reg + 8'd1;
            end
            if (cmd.fill_write) begin
                pix_reg[slot_reg] <= {scaled_g[15:8], scaled_r[15:8], scaled_b[15:8]};
            end
            if (cmd.emit_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.fill_init) begin
            slot_reg   <= start_reg;
            bright_reg <= 8'd0;
            over_reg   <= 1'b0;
        end
        else if (cmd.fill_write) begin
            slot_reg   <= (slot_reg == last_idx) ? '0 : slot_reg + 1'b1;
            bright_reg <= bright_sum[7:0];
            over_reg   <= over_reg | bright_sum[8];
        end
        if (cmd.gamma_square) begin
            sq_reg <= sq_prod;
        end
        if (cmd.gamma_cube) begin
            case (cmd.ch)
                lrhs_pkg::CH_G: gam_g_reg <= cube_sum[23:16];
                lrhs_pkg::CH_R: gam_r_reg <= cube_sum[23:16];
                lrhs_pkg::CH_B: gam_b_reg <= cube_sum[23:16];
                default: ;
            endcase
        end
        if (cmd.emit_load) begin
            pos_reg    <= 4'(cmd.emit_idx);
            out_px_reg <= pix_reg[cmd.emit_idx];
            last_reg   <= cmd.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_position = pos_reg;
    assign green        = out_px_reg.g;
    assign red          = out_px_reg.r;
    assign blue         = out_px_reg.b;
    assign frame_end    = last_reg;

endmodule
